// ===== rtl/ajpq_pkg.sv =====
// Shared codes, field widths and the sequence-number compare of the playout queue.
// Depends on nothing; the top level, the checker and the testbench refer to it by scoped names.
package ajpq_pkg;

    localparam int SEQ_W  = 16;
    localparam int FLAG_W = 8;
    localparam int WORD_W = 64;
    localparam int KIND_W = 8;
    localparam int SRC_W  = 3;
    localparam int STAT_W = 3;

    localparam logic [1:0] OP_HDR  = 2'd0;
    localparam logic [1:0] OP_PAY  = 2'd1;
    localparam logic [1:0] OP_NEXT = 2'd2;
    localparam logic [1:0] OP_RSV  = 2'd3;

    localparam logic [STAT_W-1:0] ST_ACCEPT  = 3'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 3'd1;
    localparam logic [STAT_W-1:0] ST_STALE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DUP     = 3'd3;
    localparam logic [STAT_W-1:0] ST_DELIVER = 3'd4;
    localparam logic [STAT_W-1:0] ST_CONCEAL = 3'd5;

    localparam logic [1:0] CFG_KIND  = 2'd0;
    localparam logic [1:0] CFG_MASK0 = 2'd1;
    localparam logic [1:0] CFG_MASK1 = 2'd2;

    // True when cand lies strictly after ref_seq in 16-bit wrapping order.
    function automatic logic seq_after(logic [SEQ_W-1:0] cand, logic [SEQ_W-1:0] ref_seq);
        logic [SEQ_W-1:0] d;
        d = cand - ref_seq;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

endpackage

// ===== rtl/audio_jitter_playout_queue.sv =====
// Top level of the audio jitter playout queue: sequencer, per-source state and memories.
// Depends on ajpq_pkg and ajpq_ram.
//
// Usage: a command is taken at a rising edge where i_start is high and o_busy is low.
// i_op selects a header push, a payload word push or a playout request for i_source_id.
// Each result word shows on the o_ ports for exactly one cycle with o_valid high;
// o_last marks the final word of a command. The receiver cannot stall, so results
// simply stream out as the sequencer produces them.
// A payload word is absorbed in the cycle it is taken and gives no result.
// A header walks the queued sequence numbers of its source (a read state and a compare
// state per entry), then clears the 2*CODEC_WORDS payload words of its new slot one per
// cycle through the payload memory write port.
// A playout request drops stale heads, each through a read and a compare state, copies
// the matching frame into the per-source current buffer on a first half, then emits each
// word through a read and an output state, since each word is a registered memory read.
// The block is busy for the whole command; the last word is on the ports in the first
// cycle with o_busy low, so the next command can be taken at the edge that ends it.
// Reset clears all per-source state and restores the registers; queue memories need no
// clearing because a slot is always written before use. The user must write configuration
// via i_cfg_we / i_cfg_addr / i_cfg_wdata only while idle; the block does not enforce it.
module audio_jitter_playout_queue #(
    parameter int QUEUE_DEPTH = 8,
    parameter int SOURCES     = 6,
    parameter int CODEC_WORDS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_op,
    input  logic [ajpq_pkg::KIND_W-1:0]    i_frame_kind,
    input  logic [ajpq_pkg::SRC_W-1:0]     i_source_id,
    input  logic [ajpq_pkg::SEQ_W-1:0]     i_sequence_req,
    input  logic [ajpq_pkg::FLAG_W-1:0]    i_frame_flags,
    input  logic [ajpq_pkg::WORD_W-1:0]    i_payload_word,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_addr,
    input  logic [7:0]                     i_cfg_wdata,
    output logic                           o_valid,
    output logic [ajpq_pkg::STAT_W-1:0]    o_status,
    output logic                           o_overrun,
    output logic [ajpq_pkg::WORD_W-1:0]    o_data_word,
    output logic                           o_conceal,
    output logic                           o_last
);
    localparam int FW    = 2 * CODEC_WORDS;
    localparam int SLOTS = SOURCES * QUEUE_DEPTH;
    localparam int SW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int CNW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLW   = $clog2(SLOTS);
    localparam int PAW   = $clog2(SLOTS * FW);
    localparam int CUW   = $clog2(SOURCES * FW);
    localparam int FWW   = $clog2(FW);
    localparam int KW    = $clog2(FW + 1);
    localparam int CWI   = (CODEC_WORDS > 1) ? $clog2(CODEC_WORDS) : 1;
    localparam int SFW   = ajpq_pkg::FLAG_W + ajpq_pkg::SEQ_W;

    typedef enum logic [3:0] {
        S_IDLE, S_HCHK, S_HRD, S_HCMP, S_HINS, S_HZERO,
        S_NCHK, S_NHEAD, S_NHCMP, S_NCOPY, S_ERD, S_EOUT, S_SOUT
    } t_state;

    t_state r_state;

    // Configuration.
    logic [7:0] r_audio_kind, r_mask0, r_mask1;

    // Per-source state.
    logic [QW-1:0]                  r_head    [SOURCES];
    logic [CNW-1:0]                 r_count   [SOURCES];
    logic [ajpq_pkg::SEQ_W-1:0]     r_exp     [SOURCES];
    logic                           r_known   [SOURCES];
    logic                           r_half    [SOURCES];
    logic                           r_present [SOURCES];
    logic [ajpq_pkg::FLAG_W-1:0]    r_cflags  [SOURCES];

    // Payload fill tracking.
    logic            r_fill_act;
    logic [PAW-1:0]  r_fill_base;
    logic [FWW-1:0]  r_fill_word;

    // Latched command and sequencer counters.
    logic [ajpq_pkg::KIND_W-1:0] r_kind;
    logic [ajpq_pkg::SRC_W-1:0]  r_src;
    logic [ajpq_pkg::SEQ_W-1:0]  r_seq;
    logic [ajpq_pkg::FLAG_W-1:0] r_flags;
    logic [CNW-1:0]              r_scan;
    logic [KW-1:0]               r_k;
    logic [CWI-1:0]              r_i;
    logic [PAW-1:0]              r_cp_base;
    logic                        r_nochg;
    logic [ajpq_pkg::STAT_W-1:0] r_res_status;
    logic                        r_res_overrun;

    // Registered outputs.
    logic                        r_o_valid;
    logic [ajpq_pkg::STAT_W-1:0] r_o_status;
    logic                        r_o_overrun;
    logic [ajpq_pkg::WORD_W-1:0] r_o_data;
    logic                        r_o_conceal;
    logic                        r_o_last;

    logic [SW-1:0] s_idx;
    logic          src_ok;
    assign s_idx  = SW'(r_src - 3'd1);
    assign src_ok = (r_src != '0) && ({2'b00, r_src} <= 5'(SOURCES));

    logic [QW-1:0]              cur_head;
    logic [CNW-1:0]             cur_count;
    logic [ajpq_pkg::SEQ_W-1:0] cur_exp;
    logic                       cur_known, cur_half, cur_present;
    logic [ajpq_pkg::FLAG_W-1:0] cur_flags;
    assign cur_head    = r_head[s_idx];
    assign cur_count   = r_count[s_idx];
    assign cur_exp     = r_exp[s_idx];
    assign cur_known   = r_known[s_idx];
    assign cur_half    = r_half[s_idx];
    assign cur_present = r_present[s_idx];
    assign cur_flags   = r_cflags[s_idx];

    function automatic logic [SLW-1:0] slot_at(logic [SW-1:0] s, logic [QW-1:0] hd,
                                               logic [CNW-1:0] off);
        logic [CNW:0] p;
        p = (CNW+1)'(hd) + (CNW+1)'(off);
        if (p >= (CNW+1)'(QUEUE_DEPTH)) begin
            p = p - (CNW+1)'(QUEUE_DEPTH);
        end
        return SLW'(s * QUEUE_DEPTH) + SLW'(p);
    endfunction

    // Memories.
    logic                         sf_we;
    logic [SLW-1:0]               sf_waddr, sf_raddr;
    logic [SFW-1:0]               sf_rdata;
    logic                         pay_we;
    logic [PAW-1:0]               pay_waddr, pay_raddr;
    logic [ajpq_pkg::WORD_W-1:0]  pay_wdata, pay_rdata;
    logic                         cu_we;
    logic [CUW-1:0]               cu_waddr, cu_raddr;
    logic [ajpq_pkg::WORD_W-1:0]  cu_rdata;

    logic [ajpq_pkg::SEQ_W-1:0]  q_seq;
    logic [ajpq_pkg::FLAG_W-1:0] q_flags;
    assign q_seq   = sf_rdata[ajpq_pkg::SEQ_W-1:0];
    assign q_flags = sf_rdata[SFW-1:ajpq_pkg::SEQ_W];

    logic [SLW-1:0] ins_slot;
    assign ins_slot = slot_at(s_idx, cur_head, cur_count);

    always_comb begin
        sf_we     = (r_state == S_HINS);
        sf_waddr  = ins_slot;
        sf_raddr  = slot_at(s_idx, cur_head, (r_state == S_HRD) ? r_scan : '0);

        pay_we    = 1'b0;
        pay_waddr = r_fill_base + PAW'(r_fill_word);
        pay_wdata = i_payload_word;
        if (r_state == S_IDLE && i_start && i_op == ajpq_pkg::OP_PAY && r_fill_act) begin
            pay_we = 1'b1;
        end
        if (r_state == S_HZERO) begin
            pay_we    = 1'b1;
            pay_waddr = r_fill_base + PAW'(r_k);
            pay_wdata = '0;
        end
        pay_raddr = r_cp_base + PAW'(r_k);

        cu_we    = (r_state == S_NCOPY) && (r_k != '0);
        cu_waddr = CUW'(s_idx * FW) + CUW'(r_k - KW'(1));
        cu_raddr = CUW'(s_idx * FW) + CUW'(cur_half ? CODEC_WORDS : 0) + CUW'(r_i);
    end

    ajpq_ram #(.WIDTH(SFW), .DEPTH(SLOTS)) u_seqflag (
        .i_clk(i_clk), .i_we(sf_we), .i_waddr(sf_waddr),
        .i_wdata({r_flags, r_seq}), .i_raddr(sf_raddr), .o_rdata(sf_rdata)
    );

    ajpq_ram #(.WIDTH(ajpq_pkg::WORD_W), .DEPTH(SLOTS * FW)) u_payload (
        .i_clk(i_clk), .i_we(pay_we), .i_waddr(pay_waddr),
        .i_wdata(pay_wdata), .i_raddr(pay_raddr), .o_rdata(pay_rdata)
    );

    ajpq_ram #(.WIDTH(ajpq_pkg::WORD_W), .DEPTH(SOURCES * FW)) u_current (
        .i_clk(i_clk), .i_we(cu_we), .i_waddr(cu_waddr),
        .i_wdata(pay_rdata), .i_raddr(cu_raddr), .o_rdata(cu_rdata)
    );

    // Whether the half being played holds valid audio.
    logic half_ok;
    assign half_ok = cur_present && ((cur_flags & (cur_half ? r_mask1 : r_mask0)) != '0);

    // The expected sequence as seen by the head check: an unknown source adopts its head.
    logic [ajpq_pkg::SEQ_W-1:0] head_exp;
    assign head_exp = cur_known ? cur_exp : q_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_audio_kind <= 8'd1;
            r_mask0      <= 8'd1;
            r_mask1      <= 8'd2;
            r_fill_act   <= 1'b0;
            r_o_valid    <= 1'b0;
            for (int j = 0; j < SOURCES; j++) begin
                r_head[j]    <= '0;
                r_count[j]   <= '0;
                r_exp[j]     <= '0;
                r_known[j]   <= 1'b0;
                r_half[j]    <= 1'b0;
                r_present[j] <= 1'b0;
                r_cflags[j]  <= '0;
            end
        end else begin
            r_o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ajpq_pkg::CFG_KIND:  r_audio_kind <= i_cfg_wdata;
                    ajpq_pkg::CFG_MASK0: r_mask0      <= i_cfg_wdata;
                    ajpq_pkg::CFG_MASK1: r_mask1      <= i_cfg_wdata;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind  <= i_frame_kind;
                        r_src   <= i_source_id;
                        r_seq   <= i_sequence_req;
                        r_flags <= i_frame_flags;
                        r_res_overrun <= 1'b0;
                        r_nochg <= 1'b0;
                        r_i     <= '0;
                        case (i_op)
                            ajpq_pkg::OP_PAY: begin
                                if (r_fill_act) begin
                                    r_fill_word <= r_fill_word + FWW'(1);
                                    if (r_fill_word == FWW'(FW - 1)) begin
                                        r_fill_act <= 1'b0;
                                    end
                                end
                            end
                            ajpq_pkg::OP_HDR: begin
                                r_fill_act <= 1'b0;
                                r_state    <= S_HCHK;
                            end
                            ajpq_pkg::OP_NEXT: begin
                                r_fill_act <= 1'b0;
                                r_state    <= S_NCHK;
                            end
                            default: begin
                                r_res_status <= ajpq_pkg::ST_IGNORED;
                                r_state      <= S_SOUT;
                            end
                        endcase
                    end
                end
                S_HCHK: begin
                    r_scan <= '0;
                    if (r_kind != r_audio_kind || !src_ok) begin
                        r_res_status <= ajpq_pkg::ST_IGNORED;
                        r_state      <= S_SOUT;
                    end else if (cur_known && r_seq != cur_exp &&
                                 !ajpq_pkg::seq_after(r_seq, cur_exp)) begin
                        r_res_status <= ajpq_pkg::ST_STALE;
                        r_state      <= S_SOUT;
                    end else if (cur_count == '0) begin
                        r_state <= S_HINS;
                    end else begin
                        r_state <= S_HRD;
                    end
                end
                S_HRD: begin
                    r_state <= S_HCMP;
                end
                S_HCMP: begin
                    if (q_seq == r_seq) begin
                        r_res_status <= ajpq_pkg::ST_DUP;
                        r_state      <= S_SOUT;
                    end else if (r_scan == cur_count - CNW'(1)) begin
                        // The last entry scanned is the tail: the new frame must follow it.
                        if (!ajpq_pkg::seq_after(r_seq, q_seq)) begin
                            r_res_status <= ajpq_pkg::ST_STALE;
                            r_state      <= S_SOUT;
                        end else begin
                            r_state <= S_HINS;
                        end
                    end else begin
                        r_scan  <= r_scan + CNW'(1);
                        r_state <= S_HRD;
                    end
                end
                S_HINS: begin
                    // When full, the new tail reuses the oldest slot and the head moves on.
                    if (cur_count == CNW'(QUEUE_DEPTH)) begin
                        r_res_overrun <= 1'b1;
                        r_head[s_idx] <= (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0
                                         : cur_head + QW'(1);
                    end else begin
                        r_count[s_idx] <= cur_count + CNW'(1);
                    end
                    r_fill_base <= PAW'(ins_slot * FW);
                    r_k         <= '0;
                    r_state     <= S_HZERO;
                end
                S_HZERO: begin
                    r_k <= r_k + KW'(1);
                    if (r_k == KW'(FW - 1)) begin
                        r_fill_act   <= 1'b1;
                        r_fill_word  <= '0;
                        r_res_status <= ajpq_pkg::ST_ACCEPT;
                        r_state      <= S_SOUT;
                    end
                end
                S_NCHK: begin
                    if (!src_ok) begin
                        r_res_status <= ajpq_pkg::ST_IGNORED;
                        r_state      <= S_SOUT;
                    end else if (cur_half) begin
                        r_state <= S_ERD;
                    end else if (cur_count == '0) begin
                        if (!cur_known) begin
                            r_nochg <= 1'b1;
                        end
                        r_present[s_idx] <= 1'b0;
                        r_state          <= S_ERD;
                    end else begin
                        r_state <= S_NHEAD;
                    end
                end
                S_NHEAD: begin
                    r_state <= S_NHCMP;
                end
                S_NHCMP: begin
                    r_exp[s_idx]   <= head_exp;
                    r_known[s_idx] <= 1'b1;
                    if (q_seq == head_exp) begin
                        r_cflags[s_idx] <= q_flags;
                        r_cp_base       <= PAW'(sf_raddr * FW);
                        r_k             <= '0;
                        r_state         <= S_NCOPY;
                    end else if (ajpq_pkg::seq_after(q_seq, head_exp)) begin
                        r_present[s_idx] <= 1'b0;
                        r_state          <= S_ERD;
                    end else begin
                        // Stale head: drop it and look at the next one.
                        r_head[s_idx]  <= (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0
                                          : cur_head + QW'(1);
                        r_count[s_idx] <= cur_count - CNW'(1);
                        if (cur_count == CNW'(1)) begin
                            r_present[s_idx] <= 1'b0;
                            r_state          <= S_ERD;
                        end else begin
                            r_state <= S_NHEAD;
                        end
                    end
                end
                S_NCOPY: begin
                    r_k <= r_k + KW'(1);
                    if (r_k == KW'(FW)) begin
                        r_head[s_idx]    <= (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0
                                            : cur_head + QW'(1);
                        r_count[s_idx]   <= cur_count - CNW'(1);
                        r_present[s_idx] <= 1'b1;
                        r_state          <= S_ERD;
                    end
                end
                S_ERD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    r_o_valid   <= 1'b1;
                    r_o_status  <= half_ok ? ajpq_pkg::ST_DELIVER : ajpq_pkg::ST_CONCEAL;
                    r_o_overrun <= 1'b0;
                    r_o_data    <= half_ok ? cu_rdata : '0;
                    r_o_conceal <= !half_ok;
                    r_o_last    <= (r_i == CWI'(CODEC_WORDS - 1));
                    if (r_i == CWI'(CODEC_WORDS - 1)) begin
                        if (!r_nochg) begin
                            r_half[s_idx] <= !cur_half;
                            if (cur_half) begin
                                r_present[s_idx] <= 1'b0;
                                r_exp[s_idx]     <= cur_exp + 16'd1;
                            end
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + CWI'(1);
                        r_state <= S_ERD;
                    end
                end
                S_SOUT: begin
                    r_o_valid   <= 1'b1;
                    r_o_status  <= r_res_status;
                    r_o_overrun <= r_res_overrun;
                    r_o_data    <= '0;
                    r_o_conceal <= 1'b0;
                    r_o_last    <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_overrun   = r_o_overrun;
    assign o_data_word = r_o_data;
    assign o_conceal   = r_o_conceal;
    assign o_last      = r_o_last;
endmodule

// ===== rtl/ajpq_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module ajpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ajpq_checker.sv =====
// Port-level checks on the playout queue's result words, bound to the top level.
// Depends on ajpq_pkg and audio_jitter_playout_queue.
module ajpq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_busy,
    input logic                        o_valid,
    input logic [ajpq_pkg::STAT_W-1:0] o_status,
    input logic                        o_overrun,
    input logic [ajpq_pkg::WORD_W-1:0] o_data_word,
    input logic                        o_conceal,
    input logic                        o_last
);
    // A concealed word never carries audio.
    a_conceal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_conceal |-> o_data_word == '0)
        else $error("concealed word carries data");

    // Overrun is reported only on an accepted header.
    a_overrun_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overrun |-> o_status == ajpq_pkg::ST_ACCEPT && o_last)
        else $error("overrun outside an accepted header");

    // Header and ignored results are single words.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ajpq_pkg::ST_IGNORED || o_status == ajpq_pkg::ST_STALE ||
                    o_status == ajpq_pkg::ST_DUP || o_status == ajpq_pkg::ST_ACCEPT)
        |-> o_last && !o_conceal)
        else $error("single result not marked last");

    // A word that is not the last is followed by more work.
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_busy)
        else $error("block idle before last word");
endmodule

bind audio_jitter_playout_queue ajpq_checker u_ajpq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_busy(o_busy), .o_valid(o_valid),
    .o_status(o_status), .o_overrun(o_overrun), .o_data_word(o_data_word),
    .o_conceal(o_conceal), .o_last(o_last)
);

// ===== dv/audio_jitter_playout_queue_tb.sv =====
// Self-checking testbench for the audio jitter playout queue.
// Depends on ajpq_pkg and the audio_jitter_playout_queue RTL; a directed table then random traffic.
module audio_jitter_playout_queue_tb;

    localparam int QD     = 8;
    localparam int NSRC   = 6;
    localparam int CW     = 4;
    localparam int FWORDS = 2 * CW;
    localparam int NSLOT  = NSRC * QD;
    localparam int IDLE_LIMIT = 4000;

    // One result word as the block should present it.
    typedef struct packed {
        logic [ajpq_pkg::STAT_W-1:0] status;
        logic                        overrun;
        logic [ajpq_pkg::WORD_W-1:0] data;
        logic                        conceal;
        logic                        last;
    } t_play_word;

    // One command word, with an optional typed-in first result for directed rows.
    typedef struct {
        logic [1:0]                  op;
        logic [ajpq_pkg::KIND_W-1:0] kind;
        logic [ajpq_pkg::SRC_W-1:0]  src;
        logic [ajpq_pkg::SEQ_W-1:0]  seq;
        logic [ajpq_pkg::FLAG_W-1:0] flags;
        logic [ajpq_pkg::WORD_W-1:0] word;
        bit                          typed;
        logic [ajpq_pkg::STAT_W-1:0] typed_status;
    } t_cmd;

    logic clk, rst_n;
    logic start, busy;
    logic [1:0] op;
    logic [ajpq_pkg::KIND_W-1:0] kind;
    logic [ajpq_pkg::SRC_W-1:0] src;
    logic [ajpq_pkg::SEQ_W-1:0] seq;
    logic [ajpq_pkg::FLAG_W-1:0] flags;
    logic [ajpq_pkg::WORD_W-1:0] pword;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [7:0] cfg_wdata;
    logic r_valid, r_overrun, r_conceal, r_last;
    logic [ajpq_pkg::STAT_W-1:0] r_status;
    logic [ajpq_pkg::WORD_W-1:0] r_data;

    audio_jitter_playout_queue #(.QUEUE_DEPTH(QD), .SOURCES(NSRC), .CODEC_WORDS(CW)) dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_op(op), .i_frame_kind(kind), .i_source_id(src), .i_sequence_req(seq),
        .i_frame_flags(flags), .i_payload_word(pword),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .o_valid(r_valid), .o_status(r_status), .o_overrun(r_overrun),
        .o_data_word(r_data), .o_conceal(r_conceal), .o_last(r_last)
    );

    // Shadow state of the playout queue.
    logic [7:0]                  m_kind, m_mask0, m_mask1;
    logic [ajpq_pkg::SEQ_W-1:0]  q_seq [NSLOT];
    logic [ajpq_pkg::FLAG_W-1:0] q_flags [NSLOT];
    logic [ajpq_pkg::WORD_W-1:0] q_pay [NSLOT*FWORDS];
    int                          head [NSRC];
    int                          count [NSRC];
    logic [ajpq_pkg::SEQ_W-1:0]  exp_seq [NSRC];
    bit                          exp_known [NSRC];
    bit                          half [NSRC];
    bit                          cur_ok [NSRC];
    logic [ajpq_pkg::FLAG_W-1:0] cur_flags [NSRC];
    logic [ajpq_pkg::WORD_W-1:0] cur_pay [NSRC*FWORDS];
    int                          fill_slot;   // 0 means no fill, else slot + 1
    int                          fill_idx;

    t_play_word pending_words[$];
    int  mismatches = 0;
    int  words_seen = 0;
    int  idle_cycles = 0;
    int  n_delivered = 0, n_concealed = 0, n_overrun = 0;
    bit  quiet = 0;
    t_cmd directed[$];

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic bit wraps_after(logic [ajpq_pkg::SEQ_W-1:0] a,
                                       logic [ajpq_pkg::SEQ_W-1:0] b);
        logic [ajpq_pkg::SEQ_W-1:0] d;
        d = a - b;
        return d != 16'd0 && d < 16'h8000;
    endfunction

    function automatic int slot_at(int s, int off);
        return s * QD + (head[s] + off) % QD;
    endfunction

    function automatic void drop_head(int s);
        head[s] = (head[s] + 1) % QD;
        count[s]--;
    endfunction

    function automatic void clear_state();
        m_kind = 8'd1; m_mask0 = 8'd1; m_mask1 = 8'd2;
        foreach (q_seq[i]) begin q_seq[i] = '0; q_flags[i] = '0; end
        foreach (q_pay[i]) q_pay[i] = '0;
        foreach (cur_pay[i]) cur_pay[i] = '0;
        for (int s = 0; s < NSRC; s++) begin
            head[s] = 0; count[s] = 0; exp_seq[s] = '0; exp_known[s] = 0;
            half[s] = 0; cur_ok[s] = 0; cur_flags[s] = '0;
        end
        fill_slot = 0; fill_idx = 0;
    endfunction

    function automatic void push_word(logic [ajpq_pkg::STAT_W-1:0] st, logic ov,
                                      logic [ajpq_pkg::WORD_W-1:0] d, logic cc, logic lst);
        t_play_word w;
        w.status = st; w.overrun = ov; w.data = d; w.conceal = cc; w.last = lst;
        pending_words.push_back(w);
    endfunction

    // Emits one codec half of concealment.
    function automatic void conceal_half();
        for (int i = 0; i < CW; i++)
            push_word(ajpq_pkg::ST_CONCEAL, 1'b0, '0, 1'b1, i == CW - 1);
    endfunction

    // Works out the result words of one accepted command and updates the shadow state.
    function automatic void predict_playout(t_cmd c);
        int s, slot;
        bit ok, ov;
        logic [7:0] mask;
        if (c.op == ajpq_pkg::OP_PAY) begin
            if (fill_slot != 0 && fill_idx < FWORDS) begin
                q_pay[(fill_slot - 1) * FWORDS + fill_idx] = c.word;
                fill_idx++;
                if (fill_idx >= FWORDS) fill_slot = 0;
            end
            return;
        end
        if (c.op == ajpq_pkg::OP_RSV) begin
            push_word(ajpq_pkg::ST_IGNORED, 1'b0, '0, 1'b0, 1'b1);
            return;
        end
        fill_slot = 0;
        fill_idx = 0;
        if (c.src < 1 || c.src > NSRC || (c.op == ajpq_pkg::OP_HDR && c.kind != m_kind)) begin
            push_word(ajpq_pkg::ST_IGNORED, 1'b0, '0, 1'b0, 1'b1);
            return;
        end
        s = c.src - 1;
        if (c.op == ajpq_pkg::OP_HDR) begin
            if (exp_known[s] && c.seq != exp_seq[s] && !wraps_after(c.seq, exp_seq[s])) begin
                push_word(ajpq_pkg::ST_STALE, 1'b0, '0, 1'b0, 1'b1);
                return;
            end
            for (int i = 0; i < count[s]; i++)
                if (q_seq[slot_at(s, i)] == c.seq) begin
                    push_word(ajpq_pkg::ST_DUP, 1'b0, '0, 1'b0, 1'b1);
                    return;
                end
            if (count[s] > 0 && !wraps_after(c.seq, q_seq[slot_at(s, count[s] - 1)])) begin
                push_word(ajpq_pkg::ST_STALE, 1'b0, '0, 1'b0, 1'b1);
                return;
            end
            ov = 0;
            if (count[s] >= QD) begin
                drop_head(s);
                ov = 1;
            end
            slot = slot_at(s, count[s]);
            q_seq[slot] = c.seq;
            q_flags[slot] = c.flags;
            for (int i = 0; i < FWORDS; i++) q_pay[slot * FWORDS + i] = '0;
            count[s]++;
            fill_slot = slot + 1;
            push_word(ajpq_pkg::ST_ACCEPT, ov, '0, 1'b0, 1'b1);
            return;
        end
        // Playout request.
        if (!exp_known[s]) begin
            if (count[s] == 0) begin
                conceal_half();
                return;
            end
            exp_seq[s] = q_seq[slot_at(s, 0)];
            exp_known[s] = 1;
        end
        if (!half[s]) begin
            while (count[s] > 0 && q_seq[slot_at(s, 0)] != exp_seq[s]
                   && !wraps_after(q_seq[slot_at(s, 0)], exp_seq[s]))
                drop_head(s);
            cur_ok[s] = 0;
            if (count[s] > 0 && q_seq[slot_at(s, 0)] == exp_seq[s]) begin
                slot = slot_at(s, 0);
                cur_flags[s] = q_flags[slot];
                for (int i = 0; i < FWORDS; i++)
                    cur_pay[s * FWORDS + i] = q_pay[slot * FWORDS + i];
                drop_head(s);
                cur_ok[s] = 1;
            end
        end
        mask = half[s] ? m_mask1 : m_mask0;
        ok = cur_ok[s] && (cur_flags[s] & mask) != 8'd0;
        if (ok) begin
            for (int i = 0; i < CW; i++)
                push_word(ajpq_pkg::ST_DELIVER, 1'b0, cur_pay[s * FWORDS + half[s] * CW + i],
                          1'b0, i == CW - 1);
        end else begin
            conceal_half();
        end
        half[s] = !half[s];
        if (!half[s]) begin
            cur_ok[s] = 0;
            exp_seq[s] = exp_seq[s] + 16'd1;
        end
    endfunction

    // Result checker: every strobed word is compared with the oldest expectation.
    always @(posedge clk) begin
        t_play_word w;
        if (rst_n && r_valid) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word status=%0d data=%h",
                             r_status, r_data);
            end else begin
                w = pending_words.pop_front();
                if (w.status == ajpq_pkg::ST_DELIVER) n_delivered++;
                if (w.status == ajpq_pkg::ST_CONCEAL) n_concealed++;
                if (w.overrun) n_overrun++;
                if (r_status !== w.status || r_overrun !== w.overrun || r_data !== w.data
                    || r_conceal !== w.conceal || r_last !== w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word %0d exp st=%0d ov=%0d d=%h c=%0d l=%0d got st=%0d ov=%0d d=%h c=%0d l=%0d",
                                 words_seen, w.status, w.overrun, w.data, w.conceal, w.last,
                                 r_status, r_overrun, r_data, r_conceal, r_last);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a command nor a result word moves.
    always @(posedge clk) begin
        if (rst_n && !((start && !busy) || r_valid)) idle_cycles++;
        else idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: watchdog expired with %0d words pending", pending_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drives one command word and holds it until the block takes it. The start line is
    // left high afterwards; the next idle gap, the next command or a drain settles it.
    task automatic send_cmd(t_cmd c);
        int first_idx;
        if (!quiet) begin
            while ($urandom_range(99) < 27) begin
                start <= 0;
                @(negedge clk);
            end
        end
        start <= 1; op <= c.op; kind <= c.kind; src <= c.src; seq <= c.seq;
        flags <= c.flags; pword <= c.word;
        @(posedge clk);
        while (busy) @(posedge clk);
        first_idx = pending_words.size();
        predict_playout(c);
        // Directed rows with a typed-in status also check the prediction itself.
        if (c.typed && (pending_words.size() <= first_idx ||
                        pending_words[first_idx].status != c.typed_status)) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: directed row expected status %0d", c.typed_status);
        end
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 0;
        while (pending_words.size() != 0) @(negedge clk);
        // A trailing payload word gives no result, so let the block settle.
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] v);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            ajpq_pkg::CFG_KIND:  m_kind = v;
            ajpq_pkg::CFG_MASK0: m_mask0 = v;
            ajpq_pkg::CFG_MASK1: m_mask1 = v;
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic t_cmd mk(logic [1:0] o, logic [7:0] k, logic [2:0] s, logic [15:0] q,
                                logic [7:0] f, logic [63:0] w);
        t_cmd c;
        c.op = o; c.kind = k; c.src = s; c.seq = q; c.flags = f; c.word = w;
        c.typed = 0; c.typed_status = ajpq_pkg::ST_ACCEPT;
        return c;
    endfunction

    function automatic t_cmd typed(t_cmd c, logic [ajpq_pkg::STAT_W-1:0] st);
        c.typed = 1; c.typed_status = st;
        return c;
    endfunction

    // Sends a whole frame: a header followed by a run of payload words.
    task automatic send_frame(logic [7:0] k, logic [2:0] s, logic [15:0] q,
                              logic [7:0] f, int nwords);
        send_cmd(mk(ajpq_pkg::OP_HDR, k, s, q, f, '0));
        for (int i = 0; i < nwords; i++)
            send_cmd(mk(ajpq_pkg::OP_PAY, $urandom, $urandom, $urandom, $urandom,
                        {$urandom, $urandom}));
    endtask

    logic [ajpq_pkg::SEQ_W-1:0] rnd_seq [NSRC];

    // Sends random traffic until about n command words have been taken.
    task automatic random_phase(int n);
        int s, pick, sent, nw;
        sent = 0;
        while (sent < n) begin
            s = $urandom_range(NSRC - 1);
            pick = $urandom_range(99);
            if (pick < 45) begin
                // Mostly in-order frames, sometimes skipping ahead or reaching back.
                case ($urandom_range(9))
                    0:       rnd_seq[s] = rnd_seq[s] - 16'($urandom_range(3));
                    1:       rnd_seq[s] = rnd_seq[s] + 16'($urandom_range(2, 4));
                    default: rnd_seq[s] = rnd_seq[s] + 16'd1;
                endcase
                nw = ($urandom_range(9) == 0) ? int'($urandom_range(FWORDS + 2)) : FWORDS;
                send_frame($urandom_range(9) == 0 ? 8'($urandom) : m_kind, 3'(s + 1),
                           rnd_seq[s], 8'($urandom), nw);
                sent += 1 + nw;
            end else if (pick < 90) begin
                send_cmd(mk(ajpq_pkg::OP_NEXT, $urandom, 3'(s + 1), $urandom, $urandom,
                            {$urandom, $urandom}));
                sent++;
            end else begin
                send_cmd(mk(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                            {$urandom, $urandom}));
                sent++;
            end
        end
    endtask

    initial begin
        start = 0; op = ajpq_pkg::OP_HDR; kind = '0; src = '0; seq = '0; flags = '0;
        pword = '0;
        cfg_we = 0; cfg_addr = ajpq_pkg::CFG_KIND; cfg_wdata = '0;
        rst_n = 0;
        clear_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed rows: reset behavior, bad kind and source, stale and duplicate
        // headers, interrupted fill, reserved op and field extremes.
        directed.push_back(typed(mk(ajpq_pkg::OP_NEXT, 0, 1, 0, 0, 0), ajpq_pkg::ST_CONCEAL));
        directed.push_back(typed(mk(ajpq_pkg::OP_NEXT, 0, 0, 0, 0, 0), ajpq_pkg::ST_IGNORED));
        directed.push_back(typed(mk(ajpq_pkg::OP_NEXT, 0, 7, 0, 0, 0), ajpq_pkg::ST_IGNORED));
        directed.push_back(typed(mk(ajpq_pkg::OP_HDR, 8'hFF, 1, 16'hFFFF, 8'hFF, 0),
                                 ajpq_pkg::ST_IGNORED));
        directed.push_back(typed(mk(ajpq_pkg::OP_HDR, 1, 0, 5, 3, 0), ajpq_pkg::ST_IGNORED));
        directed.push_back(typed(mk(ajpq_pkg::OP_RSV, 8'hFF, 7, 16'hFFFF, 8'hFF, '1),
                                 ajpq_pkg::ST_IGNORED));
        directed.push_back(mk(ajpq_pkg::OP_PAY, 0, 0, 0, 0, 64'hDEAD));
        directed.push_back(typed(mk(ajpq_pkg::OP_HDR, 1, 6, 16'hFFFE, 8'h03, 0),
                                 ajpq_pkg::ST_ACCEPT));
        for (int i = 0; i < FWORDS; i++)
            directed.push_back(mk(ajpq_pkg::OP_PAY, 0, 0, 0, 0,
                                  i[0] ? '1 : 64'h0123_4567_89AB_CDEF));
        directed.push_back(mk(ajpq_pkg::OP_PAY, 0, 0, 0, 0, '1));
        directed.push_back(typed(mk(ajpq_pkg::OP_HDR, 1, 6, 16'hFFFE, 0, 0), ajpq_pkg::ST_DUP));
        directed.push_back(typed(mk(ajpq_pkg::OP_HDR, 1, 6, 16'hFFFD, 0, 0),
                                 ajpq_pkg::ST_STALE));
        directed.push_back(typed(mk(ajpq_pkg::OP_HDR, 1, 6, 16'h0001, 8'h01, 0),
                                 ajpq_pkg::ST_ACCEPT));
        directed.push_back(mk(ajpq_pkg::OP_PAY, 0, 0, 0, 0, 64'h55));
        directed.push_back(mk(ajpq_pkg::OP_NEXT, 0, 6, 0, 0, 0));
        directed.push_back(mk(ajpq_pkg::OP_NEXT, 0, 6, 0, 0, 0));
        directed.push_back(mk(ajpq_pkg::OP_NEXT, 0, 6, 0, 0, 0));
        directed.push_back(mk(ajpq_pkg::OP_NEXT, 0, 6, 0, 0, 0));
        directed.push_back(mk(ajpq_pkg::OP_NEXT, 0, 6, 0, 0, 0));
        directed.push_back(typed(mk(ajpq_pkg::OP_HDR, 1, 6, 16'hFFFF, 0, 0),
                                 ajpq_pkg::ST_STALE));
        foreach (directed[i]) send_cmd(directed[i]);

        // Fill one source past its depth so the oldest frames are dropped.
        for (int i = 0; i < QD + 2; i++)
            send_frame(8'd1, 3'd2, 16'h8000 + 16'(i), 8'hFF, FWORDS);
        drain();

        for (int s = 0; s < NSRC; s++) rnd_seq[s] = 16'($urandom);
        write_reg(ajpq_pkg::CFG_KIND, 8'hFF);
        write_reg(ajpq_pkg::CFG_MASK0, 8'hFF);
        write_reg(ajpq_pkg::CFG_MASK1, 8'h00);
        random_phase(24);
        drain();

        // A stretch without any idle gaps.
        quiet = 1;
        write_reg(ajpq_pkg::CFG_KIND, 8'h00);
        write_reg(ajpq_pkg::CFG_MASK0, 8'h80);
        write_reg(ajpq_pkg::CFG_MASK1, 8'hFF);
        random_phase(24);
        drain();
        quiet = 0;

        write_reg(ajpq_pkg::CFG_KIND, 8'($urandom));
        write_reg(ajpq_pkg::CFG_MASK0, 8'($urandom));
        write_reg(ajpq_pkg::CFG_MASK1, 8'($urandom));
        random_phase(24);
        drain();

        write_reg(ajpq_pkg::CFG_KIND, 8'h01);
        write_reg(ajpq_pkg::CFG_MASK0, 8'h01);
        write_reg(ajpq_pkg::CFG_MASK1, 8'h02);
        random_phase(24);
        drain();

        $display("Covered %0d result words: %0d delivered, %0d concealed, %0d overruns.",
                 words_seen, n_delivered, n_concealed, n_overrun);
        $display("Register settings included all-ones, zero and random kinds and masks.");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
